FILE: rtl/core/page_bitmap_allocator_core_macros.svh
// Assertion macros used by the page bitmap allocator checker.
`ifndef PAGE_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_BITMAP_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pba assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pba assertion failed");

`endif

FILE: rtl/core/pba_pkg.sv
// Types and constants of the page bitmap allocator.
package pba_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned START_W = 16;
  localparam int unsigned FIELD_W = 17;

  typedef enum logic [1:0] {
    OP_LOCK      = 2'd0,
    OP_FREE      = 2'd1,
    OP_RESERVE   = 2'd2,
    OP_UNRESERVE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_WALK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic clr;
    logic load;
    logic check;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic end_now;
    logic end_next;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/pba_if.sv
// Request, response and configuration channel interfaces.
interface pba_req_if;
  import pba_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [START_W-1:0]   start_page;
  logic [FIELD_W-1:0]   page_count;
  modport source (output valid, operation, start_page, page_count, input ready);
  modport sink (input valid, operation, start_page, page_count, output ready);
endinterface

interface pba_rsp_if;
  import pba_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] free_pages;
  logic [FIELD_W-1:0] used_pages;
  logic [FIELD_W-1:0] reserved_pages;
  logic [FIELD_W-1:0] pages_changed;
  logic               out_of_range;
  modport source (output valid, free_pages, used_pages, reserved_pages, pages_changed,
                  out_of_range, input ready);
  modport sink (input valid, free_pages, used_pages, reserved_pages, pages_changed,
                out_of_range, output ready);
endinterface

interface pba_cfg_if;
  import pba_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] total_pages;
  modport source (output valid, total_pages, input ready);
  modport sink (input valid, total_pages, output ready);
endinterface

FILE: rtl/core/pba_ctrl.sv
// Controller state machine of the page bitmap allocator.
module pba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pba_pkg::sts_t sts_i,
  output pba_pkg::cmd_t cmd_o
);
  import pba_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_ISSUE;
      ST_ISSUE:  state_d = sts_i.end_now ? ST_FINISH : ST_WALK;
      ST_WALK:   if (sts_i.end_next) state_d = ST_FINISH;
      ST_FINISH: if (sts_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR:  cmd_o.clr = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_ISSUE:  cmd_o.check = 1'b1;
      ST_WALK:   cmd_o.step = 1'b1;
      ST_FINISH: cmd_o.emit = sts_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule

FILE: rtl/core/pba_dp.sv
// Datapath: bitmap RAM, run walker, page counters and result register.
module pba_dp #(
  parameter int unsigned NUM_PAGES = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pba_pkg::cmd_t                 cmd_i,
  output pba_pkg::sts_t                 sts_o,
  input  logic [pba_pkg::OP_W-1:0]      operation_i,
  input  logic [pba_pkg::START_W-1:0]   start_page_i,
  input  logic [pba_pkg::FIELD_W-1:0]   page_count_i,
  input  logic                          cfg_we_i,
  input  logic [pba_pkg::FIELD_W-1:0]   total_pages_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pba_pkg::FIELD_W-1:0]   free_pages_o,
  output logic [pba_pkg::FIELD_W-1:0]   used_pages_o,
  output logic [pba_pkg::FIELD_W-1:0]   reserved_pages_o,
  output logic [pba_pkg::FIELD_W-1:0]   pages_changed_o,
  output logic                          out_of_range_o
);
  import pba_pkg::*;

  localparam int unsigned IDX_W   = $clog2(NUM_PAGES);
  localparam int unsigned CNT_W   = $clog2(NUM_PAGES + 1);
  localparam int unsigned PAGE_W  = FIELD_W + 1;
  localparam int unsigned CMP_W   = (CNT_W > PAGE_W) ? CNT_W : PAGE_W;
  localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(NUM_PAGES);
  localparam logic [CMP_W-1:0] LIMIT_W = CMP_W'(NUM_PAGES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PAGES - 1);

  // bitmap storage
  logic mem_q [NUM_PAGES];
  logic rd_bit_q;

  op_e                op_q;
  logic [PAGE_W-1:0]  page_q;
  logic [FIELD_W-1:0] rem_q, chg_q;
  logic               oor_q;
  logic [CNT_W-1:0]   free_q, used_q, resv_q;
  logic [CNT_W-1:0]   free_d, used_d, resv_d;
  logic [IDX_W-1:0]   clr_q;

  logic               out_valid_q;
  logic [FIELD_W-1:0] out_free_q, out_used_q, out_resv_q, out_chg_q;
  logic               out_oor_q;

  logic [PAGE_W-1:0]  nxt_page;
  logic [FIELD_W-1:0] nxt_rem;
  logic [CMP_W-1:0]   page_x, nxt_x, cfg_x, free_x, used_x, resv_x;
  logic               page_oor, nxt_oor, rem_zero, nxt_zero;
  logic               setting, to_used, flip;
  logic               we, wd, rd_en;
  logic [IDX_W-1:0]   wa, ra;
  logic [CNT_W-1:0]   free_load;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v >= LIMIT_C) ? LIMIT_C : v + CNT_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] v);
    return (v == '0) ? '0 : v - CNT_W'(1);
  endfunction

  assign nxt_page = page_q + PAGE_W'(1);
  assign nxt_rem  = rem_q - FIELD_W'(1);
  assign page_x   = CMP_W'(page_q);
  assign nxt_x    = CMP_W'(nxt_page);
  assign page_oor = page_x >= LIMIT_W;
  assign nxt_oor  = nxt_x >= LIMIT_W;
  assign rem_zero = rem_q == '0;
  assign nxt_zero = nxt_rem == '0;

  assign setting = (op_q == OP_LOCK) || (op_q == OP_RESERVE);
  assign to_used = (op_q == OP_LOCK) || (op_q == OP_FREE);
  assign flip    = rd_bit_q != setting;

  assign sts_o.clr_last = clr_q == LAST_IDX;
  assign sts_o.end_now  = rem_zero || page_oor;
  assign sts_o.end_next = nxt_zero || nxt_oor;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign we    = cmd_i.clr || (cmd_i.step && flip);
  assign wa    = cmd_i.clr ? clr_q : page_x[IDX_W-1:0];
  assign wd    = cmd_i.clr ? 1'b0 : setting;
  assign rd_en = (cmd_i.check && !(rem_zero || page_oor)) ||
                 (cmd_i.step && !(nxt_zero || nxt_oor));
  assign ra    = cmd_i.step ? nxt_x[IDX_W-1:0] : page_x[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (rd_en) begin
      rd_bit_q <= mem_q[ra];
    end
  end

  assign cfg_x     = CMP_W'(total_pages_i);
  assign free_load = (cfg_x > LIMIT_W) ? LIMIT_C : cfg_x[CNT_W-1:0];

  always_comb begin
    free_d = free_q;
    used_d = used_q;
    resv_d = resv_q;
    if (cfg_we_i) begin
      free_d = free_load;
    end else if (cmd_i.step && flip) begin
      if (setting) begin
        free_d = sat_dec(free_q);
        if (to_used) used_d = sat_inc(used_q);
        else         resv_d = sat_inc(resv_q);
      end else begin
        free_d = sat_inc(free_q);
        if (to_used) used_d = sat_dec(used_q);
        else         resv_d = sat_dec(resv_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q      <= '0;
      used_q      <= '0;
      resv_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      free_q <= free_d;
      used_q <= used_d;
      resv_q <= resv_d;
      if (cmd_i.clr) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(operation_i);
      page_q <= PAGE_W'(start_page_i);
      rem_q  <= page_count_i;
      chg_q  <= '0;
      oor_q  <= 1'b0;
    end else if (cmd_i.check) begin
      oor_q <= !rem_zero && page_oor;
    end else if (cmd_i.step) begin
      page_q <= nxt_page;
      rem_q  <= nxt_rem;
      oor_q  <= !nxt_zero && nxt_oor;
      if (flip) begin
        chg_q <= chg_q + FIELD_W'(1);
      end
    end
  end

  assign free_x = CMP_W'(free_q);
  assign used_x = CMP_W'(used_q);
  assign resv_x = CMP_W'(resv_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_free_q <= free_x[FIELD_W-1:0];
      out_used_q <= used_x[FIELD_W-1:0];
      out_resv_q <= resv_x[FIELD_W-1:0];
      out_chg_q  <= chg_q;
      out_oor_q  <= oor_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign free_pages_o     = out_free_q;
  assign used_pages_o     = out_used_q;
  assign reserved_pages_o = out_resv_q;
  assign pages_changed_o  = out_chg_q;
  assign out_of_range_o   = out_oor_q;

endmodule

FILE: rtl/core/page_bitmap_allocator_core.sv
// Top level of the page bitmap allocator: controller plus datapath.
//
//   channel | dir | transfer when      | payload
//   --------+-----+--------------------+-------------------------------------------------
//   req_i   | in  | valid && ready     | operation, start_page, page_count
//   rsp_o   | out | valid && ready     | free/used/reserved_pages, pages_changed, out_of_range
//   cfg_i   | in  | valid && ready     | total_pages (ready is always high)
//
// After the request transfer the controller passes ISSUE, then WALK once per page of the run
// (stopping early if the run goes off the end of the bitmap), then FINISH, which loads the
// output register; the next request transfers back in IDLE. One page per cycle through the bitmap RAM.
// After reset a clearing pass zeroes every bitmap entry; req_i.ready stays low meanwhile.
// A request can be taken while the previous result waits in the output register; a
// finished request waits for that register to empty.
module page_bitmap_allocator_core #(
  parameter int unsigned NUM_PAGES = 65536
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  pba_req_if.sink        req_i,
  pba_rsp_if.source      rsp_o,
  pba_cfg_if.sink        cfg_i
);
  import pba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  pba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pba_dp #(
    .NUM_PAGES (NUM_PAGES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .operation_i      (req_i.operation),
    .start_page_i     (req_i.start_page),
    .page_count_i     (req_i.page_count),
    .cfg_we_i         (cfg_i.valid),
    .total_pages_i    (cfg_i.total_pages),
    .out_valid_o      (rsp_o.valid),
    .out_ready_i      (rsp_o.ready),
    .free_pages_o     (rsp_o.free_pages),
    .used_pages_o     (rsp_o.used_pages),
    .reserved_pages_o (rsp_o.reserved_pages),
    .pages_changed_o  (rsp_o.pages_changed),
    .out_of_range_o   (rsp_o.out_of_range)
  );

endmodule

FILE: rtl/core/pba_checker.sv
// Port-level assertion checker for the page bitmap allocator, with its bind.
`include "page_bitmap_allocator_core_macros.svh"

module pba_checker #(
  parameter int unsigned NUM_PAGES = 65536
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic [pba_pkg::FIELD_W-1:0] free_pages_i,
  input logic [pba_pkg::FIELD_W-1:0] used_pages_i,
  input logic [pba_pkg::FIELD_W-1:0] reserved_pages_i
);

  // a result held back by the sink keeps its counters
  `PBA_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(free_pages_i) && $stable(used_pages_i) && $stable(reserved_pages_i))

  // a request transfer closes the request channel for the walk
  `PBA_ASSERT_NEXT(a_req_busy, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)

  // counters never pass the bitmap size (checked for up to 65536 pages)
  `PBA_ASSERT_NOW(a_cnt_limit, clk_i, rst_ni, rsp_valid_i, (NUM_PAGES > 65536) || (free_pages_i <= NUM_PAGES && used_pages_i <= NUM_PAGES && reserved_pages_i <= NUM_PAGES))

endmodule

bind page_bitmap_allocator_core pba_checker #(
  .NUM_PAGES (NUM_PAGES)
) u_pba_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .free_pages_i     (rsp_o.free_pages),
  .used_pages_i     (rsp_o.used_pages),
  .reserved_pages_i (rsp_o.reserved_pages)
);
